// ===== rtl/core/cvpm_pkg.sv =====
// Shared constants and control types for the cell voltage pack monitor.
`timescale 1ns / 1ps
package cvpm_pkg;

	localparam int CELLS = 16;
	localparam int POS_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam int CV_W  = 13;
	localparam int SUM_W = 18;
	localparam int CUR_W = 19;
	localparam int PWR_W = 37;
	localparam int PCT_W = 7;
	localparam int NUM_W = SUM_W + PCT_W;
	localparam int IDX_W = 2;
	localparam int STEP_W = 3;
	localparam int DIV_STEPS = PCT_W;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [IDX_W-1:0] REG_CELL_MIN   = 2'd0;
	localparam logic [IDX_W-1:0] REG_CELL_MAX   = 2'd1;
	localparam logic [IDX_W-1:0] REG_PACK_EMPTY = 2'd2;
	localparam logic [IDX_W-1:0] REG_PACK_FULL  = 2'd3;

	localparam logic [CV_W-1:0]  RST_CELL_MIN   = 13'd2500;
	localparam logic [CV_W-1:0]  RST_CELL_MAX   = 13'd4250;
	localparam logic [SUM_W-1:0] RST_PACK_EMPTY = 18'd48000;
	localparam logic [SUM_W-1:0] RST_PACK_FULL  = 18'd67200;

	typedef struct packed {
		logic              accept;
		logic              prep;
		logic              div_step;
		logic [STEP_W-1:0] step;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic last_cell;
	} sts_t;

endpackage

// ===== rtl/core/cvpm_ctrl.sv =====
// Controller state machine that sequences accumulation, division and result hand-off.
`timescale 1ns / 1ps
module cvpm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  cvpm_pkg::sts_t sts,
	output cvpm_pkg::cmd_t cmd
);
	import cvpm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.accept   = in_valid && in_ready;
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.step     = cnt_q;
		cmd.load_out = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept && sts.last_cell) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= STEP_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_HOLD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/cvpm_dp.sv =====
// Datapath with configuration, scan accumulators, power product and charge divider.
`timescale 1ns / 1ps
module cvpm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cvpm_pkg::IDX_W-1:0]            cfg_index,
	input  logic [cvpm_pkg::SUM_W-1:0]            cfg_data,
	input  logic [cvpm_pkg::CV_W-1:0]             cell_mv,
	input  logic signed [cvpm_pkg::CUR_W-1:0]     current_ma,
	input  cvpm_pkg::cmd_t                        cmd,
	output cvpm_pkg::sts_t                        sts,
	output logic [cvpm_pkg::SUM_W-1:0]            total_mv,
	output logic [cvpm_pkg::CV_W-1:0]             average_mv,
	output logic [cvpm_pkg::CV_W-1:0]             lowest_mv,
	output logic [cvpm_pkg::CV_W-1:0]             highest_mv,
	output logic [cvpm_pkg::CV_W-1:0]             spread_mv,
	output logic                                  pack_ok,
	output logic signed [cvpm_pkg::PWR_W-1:0]     power_uw,
	output logic [cvpm_pkg::PCT_W-1:0]            charge_percent
);
	import cvpm_pkg::*;

	logic [CV_W-1:0]         cell_min_q;
	logic [CV_W-1:0]         cell_max_q;
	logic [SUM_W-1:0]        pack_empty_q;
	logic [SUM_W-1:0]        pack_full_q;

	logic [POS_W-1:0]        pos_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CV_W-1:0]         low_q;
	logic [CV_W-1:0]         high_q;
	logic                    ok_q;
	logic signed [CUR_W-1:0] cur_q;

	logic signed [PWR_W-1:0] power_q;
	logic                    is_empty_q;
	logic                    is_full_q;
	logic [NUM_W-1:0]        rem_q;
	logic [SUM_W-1:0]        den_q;
	logic [PCT_W-1:0]        quo_q;

	logic                    cell_ok;
	logic                    first;
	logic signed [SUM_W+CUR_W:0] prod;
	logic [SUM_W-1:0]        diff;
	logic [NUM_W-1:0]        num;
	logic [NUM_W-1:0]        den_sh;
	logic [SUM_W-1:0]        avg_full;

	assign cell_ok       = (cell_mv >= cell_min_q) && (cell_mv <= cell_max_q);
	assign first         = (pos_q == '0);
	assign sts.last_cell = (pos_q == POS_W'(CELLS - 1));

	assign prod     = $signed({1'b0, sum_q}) * cur_q;
	assign diff     = sum_q - pack_empty_q;
	assign num      = NUM_W'(diff) * NUM_W'(PCT_FULL);
	assign den_sh   = NUM_W'(den_q) << cmd.step;
	assign avg_full = sum_q / SUM_W'(CELLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_min_q   <= RST_CELL_MIN;
			cell_max_q   <= RST_CELL_MAX;
			pack_empty_q <= RST_PACK_EMPTY;
			pack_full_q  <= RST_PACK_FULL;
			pos_q        <= '0;
			sum_q        <= '0;
			low_q        <= '0;
			high_q       <= '0;
			ok_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CELL_MIN:   cell_min_q   <= cfg_data[CV_W-1:0];
					REG_CELL_MAX:   cell_max_q   <= cfg_data[CV_W-1:0];
					REG_PACK_EMPTY: pack_empty_q <= cfg_data;
					REG_PACK_FULL:  pack_full_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (first) begin
					sum_q  <= SUM_W'(cell_mv);
					low_q  <= cell_mv;
					high_q <= cell_mv;
					ok_q   <= cell_ok;
				end else begin
					sum_q <= sum_q + SUM_W'(cell_mv);
					if (cell_mv < low_q) begin
						low_q <= cell_mv;
					end
					if (cell_mv > high_q) begin
						high_q <= cell_mv;
					end
					ok_q <= ok_q & cell_ok;
				end
				if (sts.last_cell) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.last_cell) begin
			cur_q <= current_ma;
		end
		if (cmd.prep) begin
			power_q    <= prod[PWR_W-1:0];
			is_empty_q <= (sum_q <= pack_empty_q);
			is_full_q  <= (sum_q >= pack_full_q);
			rem_q      <= num;
			den_q      <= pack_full_q - pack_empty_q;
			quo_q      <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= den_sh) begin
				rem_q           <= rem_q - den_sh;
				quo_q[cmd.step] <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			total_mv   <= sum_q;
			average_mv <= avg_full[CV_W-1:0];
			lowest_mv  <= low_q;
			highest_mv <= high_q;
			spread_mv  <= high_q - low_q;
			pack_ok    <= ok_q;
			power_uw   <= power_q;
			if (is_empty_q) begin
				charge_percent <= '0;
			end else if (is_full_q) begin
				charge_percent <= PCT_FULL;
			end else begin
				charge_percent <= quo_q;
			end
		end
	end

endmodule

// ===== rtl/core/cell_voltage_pack_monitor_top.sv =====
// The last cell of a scan is followed by setup, a restoring divider for the
// charge percentage, and the output load before its result is shown; the load
// waits while a result still shown has not been taken (out_ready).
// Throughput: one cell per cycle mid-scan; in_ready is low until a result loads.
// Reset: arst_n clears the scan state and loads the default limits asynchronously.
`timescale 1ns / 1ps
module cell_voltage_pack_monitor_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cvpm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [cvpm_pkg::SUM_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cvpm_pkg::CV_W-1:0]         cell_mv,
	input  logic signed [cvpm_pkg::CUR_W-1:0] current_ma,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cvpm_pkg::SUM_W-1:0]        total_mv,
	output logic [cvpm_pkg::CV_W-1:0]         average_mv,
	output logic [cvpm_pkg::CV_W-1:0]         lowest_mv,
	output logic [cvpm_pkg::CV_W-1:0]         highest_mv,
	output logic [cvpm_pkg::CV_W-1:0]         spread_mv,
	output logic                              pack_ok,
	output logic signed [cvpm_pkg::PWR_W-1:0] power_uw,
	output logic [cvpm_pkg::PCT_W-1:0]        charge_percent
);
	import cvpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cvpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cvpm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cell_mv        (cell_mv),
		.current_ma     (current_ma),
		.cmd            (cmd),
		.sts            (sts),
		.total_mv       (total_mv),
		.average_mv     (average_mv),
		.lowest_mv      (lowest_mv),
		.highest_mv     (highest_mv),
		.spread_mv      (spread_mv),
		.pack_ok        (pack_ok),
		.power_uw       (power_uw),
		.charge_percent (charge_percent)
	);

endmodule
